@@ hw/rtl/asu_pkg.sv @@
// Shared constants, control struct and coefficient functions for the arcsine series unit.
package asu_pkg;

  localparam int ASU_MAX_TERMS = 16;
  localparam int ASU_FRAC_BITS = 16;

  localparam int TC_W = 5;
  localparam logic [TC_W-1:0] TERM_COUNT_RST = 5'd8;

  // Coefficients are built in Q48 and rounded half up to the working precision.
  localparam int COEF_Q = 48;

  // Register stages of the degree converter.
  localparam int DEG_LAT = 5;

  localparam longint unsigned DEG_NUM    = 64'd1800000000;
  localparam longint unsigned PI_E7      = 64'd31415926;
  localparam longint unsigned HALF_PI_E7 = 64'd15707963;
  localparam longint unsigned SCALE_E7   = 64'd10000000;

  typedef struct packed {
    logic            valid;
    logic            neg;
    logic [TC_W-1:0] terms;
  } asu_ctl_t;

  // Truncating unsigned long division, used only while building constants.
  function automatic logic [63:0] asu_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Series coefficient (2n-1)!!/((2n)!!(2n+1)) rounded half up to f fraction bits.
  function automatic logic [63:0] asu_coef(input int n, input int f);
    logic [63:0] c;
    logic [63:0] odd;
    logic [63:0] den;
    c = 64'd1 << COEF_Q;
    for (int k = 1; k <= n; k++) begin
      odd = 64'(2 * k - 1);
      den = 64'(2 * k) * 64'(2 * k + 1);
      c   = asu_udiv(c * odd * odd, den);
    end
    return (c + (64'd1 << (COEF_Q - f - 1))) >> (COEF_Q - f);
  endfunction

endpackage

@@ hw/rtl/asu_term_stage.sv @@
// One pipeline stage of the series: advances the odd power and adds at most one term.
module asu_term_stage
  import asu_pkg::*;
#(
  parameter int FRAC_BITS = ASU_FRAC_BITS,
  parameter int STAGE     = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  asu_ctl_t             ctl_in,
  input  logic [FRAC_BITS:0]   x2_in,
  input  logic [FRAC_BITS:0]   p_in,
  input  logic [FRAC_BITS+2:0] sum_in,
  output asu_ctl_t             ctl_out,
  output logic [FRAC_BITS:0]   x2_out,
  output logic [FRAC_BITS:0]   p_out,
  output logic [FRAC_BITS+2:0] sum_out
);

  localparam int PW   = FRAC_BITS + 1;
  localparam int SW   = FRAC_BITS + 3;
  localparam int TW   = 2 * FRAC_BITS + 1;
  localparam int TERM = STAGE - 1;
  localparam logic [FRAC_BITS-1:0] COEF = FRAC_BITS'(asu_coef(TERM, FRAC_BITS));
  localparam logic [2*PW-1:0] RND_P = (2 * PW)'(1) << (FRAC_BITS - 1);
  localparam logic [TW-1:0]   RND_T = TW'(1) << (FRAC_BITS - 1);

  logic [2*PW-1:0] pp;
  logic [TW-1:0]   tp;
  logic [PW-1:0]   term;
  logic            add_term;

  // The power for this stage and the term of the previous power run side by side.
  assign pp       = (2 * PW)'(p_in) * (2 * PW)'(x2_in) + RND_P;
  assign tp       = TW'(COEF) * TW'(p_in) + RND_T;
  assign term     = tp[FRAC_BITS +: PW];
  assign add_term = (TERM >= 1) && (int'(ctl_in.terms) >= TERM);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_out  <= x2_in;
      p_out   <= pp[FRAC_BITS +: PW];
      sum_out <= sum_in + (add_term ? SW'(term) : SW'(0));
    end
  end

endmodule

@@ hw/rtl/asu_deg_conv.sv @@
// Radians to degrees, round(r * 180 / pi), by reciprocal multiplication with one correction.
module asu_deg_conv
  import asu_pkg::*;
#(
  parameter int FRAC_BITS = ASU_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS+1:0] r_in,
  output logic [FRAC_BITS+1:0] r_out,
  output logic [FRAC_BITS+7:0] deg_out
);

  localparam int AW = FRAC_BITS + 2;
  localparam int DW = FRAC_BITS + 8;
  localparam int NW = AW + 24;
  localparam int LW = NW / 2;
  localparam int HW = NW - LW;
  localparam int PLW = LW + AW;
  localparam int PHW = HW + AW;
  localparam int QSW = NW + AW + 1;
  localparam int PRW = AW + 25;
  localparam longint unsigned Q0 = DEG_NUM / PI_E7;
  localparam longint unsigned R0 = DEG_NUM % PI_E7;
  localparam logic [24:0]   DIV   = 25'(PI_E7);
  localparam logic [23:0]   R0_C  = 24'(R0);
  localparam logic [5:0]    Q0_C  = 6'(Q0);
  localparam logic [23:0]   BIAS  = 24'(HALF_PI_E7);
  localparam logic [AW-1:0] RECIP = AW'((64'd1 << NW) / PI_E7);

  logic [AW-1:0]  r_d [DEG_LAT];
  logic [NW-1:0]  n1, n2, n3, n4;
  logic [DW-1:0]  base1, base2, base3, base4;
  logic [PHW-1:0] ph;
  logic [PLW-1:0] pl;
  logic [QSW-1:0] qsum;
  logic [AW-1:0]  qe3, qe4;
  logic [PRW-1:0] prod4;
  logic [NW-1:0]  rem;
  logic           fix;

  // The integer part of 180/pi is split off, so only the remainder fraction is divided.
  assign qsum = QSW'({ph, {LW{1'b0}}}) + QSW'(pl);
  assign rem  = n4 - NW'(prod4);
  // The estimate is low by at most one.
  assign fix  = rem >= NW'(DIV);

  always_ff @(posedge clk) begin
    if (en) begin
      r_d[0] <= r_in;
      for (int i = 1; i < DEG_LAT; i++) begin
        r_d[i] <= r_d[i-1];
      end
      n1      <= NW'(r_in) * NW'(R0_C) + NW'(BIAS);
      base1   <= DW'(r_in) * DW'(Q0_C);
      ph      <= PHW'(n1[NW-1:LW]) * PHW'(RECIP);
      pl      <= PLW'(n1[LW-1:0]) * PLW'(RECIP);
      n2      <= n1;
      base2   <= base1;
      qe3     <= qsum[NW +: AW];
      n3      <= n2;
      base3   <= base2;
      prod4   <= PRW'(qe3) * PRW'(DIV);
      qe4     <= qe3;
      n4      <= n3;
      base4   <= base3;
      deg_out <= base4 + DW'(qe4) + DW'(fix);
    end
  end

  assign r_out = r_d[DEG_LAT-1];

endmodule

@@ hw/rtl/arcsine_series_unit.sv @@
// Top level of the arcsine series unit: argument clamp, series pipeline and angle outputs.
//
//  Channel  Handshake            Payload (lowest bit first)
//  s_       s_tvalid, s_tready   s_tdata: sine_value
//  m_       m_tvalid, m_tready   m_tdata: asin_rad, acos_rad, asin_deg, acos_deg
//  cfg_     cfg_valid, cfg_ready cfg_data: term_count
//
// One argument is taken per cycle unless the result side stalls; the path runs through the clamp
// and square stages, the series chain and the five-stage degree converter.
// Reset clears all valid bits and loads term_count with 8.
// When the result side stalls, the whole pipeline holds and one more request is
// held in an input skid register, so s_tready depends only on registered state.
module arcsine_series_unit
  import asu_pkg::*;
#(
  parameter int MAX_TERMS = ASU_MAX_TERMS,
  parameter int FRAC_BITS = ASU_FRAC_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // sine_value
  input  logic [((FRAC_BITS+2+7)/8)*8-1:0]        s_tdata,
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // asin_rad, acos_rad, asin_deg, acos_deg
  output logic [((4*FRAC_BITS+20+7)/8)*8-1:0]     m_tdata,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [TC_W-1:0]                         cfg_data
);

  localparam int IN_W   = FRAC_BITS + 2;
  localparam int RAD_W  = FRAC_BITS + 2;
  localparam int DEG_W  = FRAC_BITS + 8;
  localparam int PW     = FRAC_BITS + 1;
  localparam int SW     = FRAC_BITS + 3;
  localparam int OUT_TW = ((4 * FRAC_BITS + 20 + 7) / 8) * 8;
  localparam int LAST   = MAX_TERMS + 1;
  localparam logic [PW-1:0]     ONE     = PW'(1) << FRAC_BITS;
  localparam logic [RAD_W-1:0]  HALF_PI =
    RAD_W'(((HALF_PI_E7 << FRAC_BITS) + SCALE_E7 / 2) / SCALE_E7);
  localparam logic [2*PW-1:0]   RND_SQ  = (2 * PW)'(1) << (FRAC_BITS - 1);

  logic [TC_W-1:0] term_count;
  logic [TC_W-1:0] terms_sat;

  logic            en;
  logic            skid_valid;
  logic [IN_W-1:0] skid_data;
  logic            in_valid;
  logic [IN_W-1:0] in_x;
  logic            in_neg;
  logic [IN_W-1:0] in_mag;

  asu_ctl_t        ctl0;
  logic [PW-1:0]   mag0;
  logic [2*PW-1:0] sq;

  asu_ctl_t        ctl_t [LAST+1];
  logic [PW-1:0]   x2_t  [LAST+1];
  logic [PW-1:0]   p_t   [LAST+1];
  logic [SW-1:0]   sum_t [LAST+1];

  logic [RAD_W-1:0] sum_sat;
  asu_ctl_t         ctl_p;
  logic [RAD_W-1:0] asin_mag_p;
  logic [RAD_W-1:0] acos_p;

  asu_ctl_t         ctl_d [DEG_LAT];
  logic [RAD_W-1:0] asin_mag_d;
  logic [RAD_W-1:0] acos_d;
  logic [DEG_W-1:0] asin_deg_mag;
  logic [DEG_W-1:0] acos_deg_d;

  logic [RAD_W-1:0] asin_rad;
  logic [RAD_W-1:0] acos_rad;
  logic [DEG_W-1:0] asin_deg;
  logic [DEG_W-1:0] acos_deg;

  // Configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= TERM_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      term_count <= cfg_data;
    end
  end

  assign terms_sat = (int'(term_count) > MAX_TERMS) ? TC_W'(MAX_TERMS) : term_count;

  // Input side and skid register
  assign en       = !m_tvalid || m_tready;
  assign s_tready = !skid_valid;
  assign in_valid = skid_valid || s_tvalid;
  assign in_x     = skid_valid ? skid_data : s_tdata[IN_W-1:0];
  assign in_neg   = in_x[IN_W-1];
  assign in_mag   = in_neg ? IN_W'(-in_x) : in_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && s_tvalid && s_tready) begin
      skid_data <= s_tdata[IN_W-1:0];
    end
  end

  // Clamp stage
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0.valid <= 1'b0;
    end else if (en) begin
      ctl0.valid <= in_valid;
      ctl0.neg   <= in_neg;
      ctl0.terms <= terms_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0 <= (in_mag > IN_W'(ONE)) ? ONE : in_mag[PW-1:0];
    end
  end

  // Square stage
  assign sq = (2 * PW)'(mag0) * (2 * PW)'(mag0) + RND_SQ;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_t[0].valid <= 1'b0;
    end else if (en) begin
      ctl_t[0] <= ctl0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_t[0]  <= sq[FRAC_BITS +: PW];
      p_t[0]   <= mag0;
      sum_t[0] <= SW'(mag0);
    end
  end

  // Series chain, at most one term per stage
  for (genvar k = 1; k <= LAST; k++) begin : g_term
    asu_term_stage #(
      .FRAC_BITS (FRAC_BITS),
      .STAGE     (k)
    ) u_term (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_t[k-1]),
      .x2_in   (x2_t[k-1]),
      .p_in    (p_t[k-1]),
      .sum_in  (sum_t[k-1]),
      .ctl_out (ctl_t[k]),
      .x2_out  (x2_t[k]),
      .p_out   (p_t[k]),
      .sum_out (sum_t[k])
    );
  end

  // Saturate at pi/2 and form the arccosine
  assign sum_sat = (sum_t[LAST] > SW'(HALF_PI)) ? HALF_PI : sum_t[LAST][RAD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p.valid <= 1'b0;
    end else if (en) begin
      ctl_p <= ctl_t[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      asin_mag_p <= sum_sat;
      acos_p     <= ctl_t[LAST].neg ? HALF_PI + sum_sat : HALF_PI - sum_sat;
    end
  end

  // Degree conversion
  asu_deg_conv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_asin_deg (
    .clk     (clk),
    .en      (en),
    .r_in    (asin_mag_p),
    .r_out   (asin_mag_d),
    .deg_out (asin_deg_mag)
  );

  asu_deg_conv #(
    .FRAC_BITS (FRAC_BITS)
  ) u_acos_deg (
    .clk     (clk),
    .en      (en),
    .r_in    (acos_p),
    .r_out   (acos_d),
    .deg_out (acos_deg_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEG_LAT; i++) begin
        ctl_d[i].valid <= 1'b0;
      end
    end else if (en) begin
      ctl_d[0] <= ctl_p;
      for (int i = 1; i < DEG_LAT; i++) begin
        ctl_d[i] <= ctl_d[i-1];
      end
    end
  end

  // Output register; the sign of the argument is applied to the arcsine here.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ctl_d[DEG_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      asin_rad <= ctl_d[DEG_LAT-1].neg ? RAD_W'(-asin_mag_d) : asin_mag_d;
      acos_rad <= acos_d;
      asin_deg <= ctl_d[DEG_LAT-1].neg ? DEG_W'(-asin_deg_mag) : asin_deg_mag;
      acos_deg <= acos_deg_d;
    end
  end

  assign m_tdata = OUT_TW'({acos_deg, asin_deg, acos_rad, asin_rad});

`ifndef SYNTHESIS
  a_acos_pairs_asin: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> acos_rad == RAD_W'(HALF_PI - asin_rad))
    else $error("arccosine does not equal pi/2 minus arcsine");

  a_asin_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(asin_rad) <= $signed(HALF_PI)) &&
                 ($signed(asin_rad) >= -$signed(HALF_PI)))
    else $error("arcsine outside plus or minus pi/2");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !en) |=> skid_valid && $stable(skid_data))
    else $error("skid register lost a held request");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    ctl0.valid |-> mag0 <= ONE)
    else $error("argument magnitude above one after clamp");
`endif

endmodule
